[src/sccb_rm_pkg.sv]
// Package for the SCCB register master: request and result types, phase kinds,
// sequence step constants and the step-to-phase decode table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sccb_rm_pkg;

  // One tick request, optionally carrying a command.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] reg_address;
    logic [7:0] write_data;
    logic       sda_in;
  } req_t;

  // Line levels and status for one tick.
  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic       failed;
    logic [7:0] read_data;
  } res_t;

  typedef enum logic [1:0] {
    ActTick  = 2'd0,
    ActWrite = 2'd1,
    ActRead  = 2'd2,
    ActNone  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CfgDevAddr = 2'd0,
    CfgTicks   = 2'd1
  } cfg_index_e;

  // What a sequence step does to the lines when its phase begins, and what
  // happens at the end of its phase.
  typedef enum logic [3:0] {
    KindNone,
    KindSdaHi,
    KindSdaLo,
    KindSclHi,
    KindSclLo,
    KindWrBit,
    KindWrHigh,
    KindWrLow,
    KindRelease,
    KindAckHigh,
    KindAckLow,
    KindDrive,
    KindRdHigh,
    KindRdLow
  } kind_e;

  localparam logic [7:0] DevAddrReset = 8'h42;
  localparam logic [7:0] TicksReset   = 8'd1;

  localparam logic [5:0] StepIdle      = 6'd0;
  localparam logic [5:0] StepFirst     = 6'd1;
  localparam logic [5:0] StepAddrLast  = 6'd11;
  localparam logic [5:0] StepRegFirst  = 6'd12;
  localparam logic [5:0] StepRegLast   = 6'd18;
  localparam logic [5:0] StepWrData    = 6'd19;
  localparam logic [5:0] StepDataLast  = 6'd25;
  localparam logic [5:0] StepWrDone    = 6'd28;
  localparam logic [5:0] StepRdStop    = 6'd29;
  localparam logic [5:0] StepRdDone    = 6'd53;
  localparam logic [5:0] StepFail      = 6'd54;
  localparam logic [5:0] StepFailDone  = 6'd58;

  function automatic kind_e step_kind(input logic [5:0] s);
    kind_e k;
    case (s)
      6'd1, 6'd28, 6'd31, 6'd32, 6'd47, 6'd53, 6'd58: k = KindSdaHi;
      6'd2, 6'd27, 6'd30, 6'd33, 6'd48, 6'd52, 6'd57: k = KindSclHi;
      6'd3, 6'd26, 6'd29, 6'd34, 6'd50, 6'd51, 6'd56: k = KindSdaLo;
      6'd4, 6'd35, 6'd49, 6'd54:                      k = KindSclLo;
      6'd5, 6'd12, 6'd19, 6'd36:                      k = KindWrBit;
      6'd6, 6'd13, 6'd20, 6'd37:                      k = KindWrHigh;
      6'd7, 6'd14, 6'd21, 6'd38:                      k = KindWrLow;
      6'd8, 6'd15, 6'd22, 6'd39, 6'd43:               k = KindRelease;
      6'd9, 6'd16, 6'd23, 6'd40:                      k = KindAckHigh;
      6'd10, 6'd17, 6'd24, 6'd41:                     k = KindAckLow;
      6'd11, 6'd18, 6'd25, 6'd42, 6'd46, 6'd55:       k = KindDrive;
      6'd44:                                          k = KindRdHigh;
      6'd45:                                          k = KindRdLow;
      default:                                        k = KindNone;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[src/sccb_register_master.sv]
// Top level of the SCCB register master: sequencer, configuration registers
// and result register. Depends on sccb_rm_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Each request is one timing tick of an SCCB master that performs single
// camera register writes and reads. While idle, a request with action write
// or read latches the register index (and data byte) and the transaction
// starts on that same tick; commands that arrive while busy are ignored. Every
// line phase lasts ticks_per_phase requests (zero acts as one). Acknowledge
// and read bits are sampled from sda_in on the last tick of a clock-high
// phase. A missing acknowledge ends the transaction with stop and failed set.
// Every request gives exactly one result, carrying the line levels after that
// tick plus busy, done, failed and read_data. The block takes one request per
// clock cycle: all the work of a tick is a short decode and update between
// the state registers and the result register, and a request is taken
// whenever the result register is empty or is being read in the same cycle.
// Configuration writes are always accepted and take effect on the next tick.
module sccb_register_master (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire sccb_rm_pkg::req_t in_req_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      sccb_rm_pkg::res_t out_res_o,
  input  wire logic              cfg_valid_i,
  output      logic              cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [7:0]        cfg_data_i
);
  import sccb_rm_pkg::*;

  // Configuration registers.
  logic [7:0] dev_addr_q;
  logic [7:0] ticks_q;

  // Sequencer state.
  logic [5:0] step_q, step_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] held_reg_q, held_reg_d;
  logic [7:0] held_data_q, held_data_d;
  logic       is_read_q, is_read_d;
  logic [7:0] phase_q, phase_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       en_q, en_d;
  logic [7:0] captured_q, captured_d;

  // Result register.
  logic       out_valid_q;
  res_t       out_res_q;
  res_t       res_d;

  logic       accept;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // One tick of the sequencer. The phase entry action is applied first, then
  // the end-of-phase update, in that order, so both can happen on one tick.
  always_comb begin : p_tick
    logic [5:0] s;
    logic [5:0] nxt;
    logic [7:0] tpp;
    logic [7:0] phase_inc;
    logic [7:0] load_byte;
    logic       is_cmd;
    kind_e      kind;

    step_d      = step_q;
    bit_d       = bit_q;
    shift_d     = shift_q;
    held_reg_d  = held_reg_q;
    held_data_d = held_data_q;
    is_read_d   = is_read_q;
    phase_d     = phase_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    en_d        = en_q;
    captured_d  = captured_q;
    res_d       = '0;

    tpp    = (ticks_q == 8'd0) ? 8'd1 : ticks_q;
    is_cmd = (in_req_i.action == ActWrite) || (in_req_i.action == ActRead);

    // A step past the last one cannot occur; it is handled as idle.
    if (step_q == StepIdle || step_q > StepFailDone) begin
      step_d = StepIdle;
      if (is_cmd) begin
        held_reg_d  = in_req_i.reg_address;
        held_data_d = in_req_i.write_data;
        is_read_d   = (in_req_i.action == ActRead);
        step_d      = StepFirst;
        phase_d     = 8'd0;
        bit_d       = 3'd0;
        shift_d     = 8'd0;
      end
    end

    s    = step_d;
    nxt  = s + 6'd1;
    kind = step_kind(s);

    if (s != StepIdle) begin
      if (phase_d == 8'd0) begin
        if (s <= StepAddrLast) begin
          load_byte = dev_addr_q;
        end else if (s <= StepRegLast) begin
          load_byte = held_reg_d;
        end else if (s <= StepDataLast) begin
          load_byte = held_data_d;
        end else begin
          load_byte = dev_addr_q + 8'd1;
        end
        case (kind)
          KindSdaHi:                                   sda_d = 1'b1;
          KindSdaLo:                                   sda_d = 1'b0;
          KindSclHi, KindWrHigh, KindAckHigh, KindRdHigh: scl_d = 1'b1;
          KindSclLo, KindWrLow, KindAckLow, KindRdLow:    scl_d = 1'b0;
          KindWrBit: begin
            if (bit_d == 3'd0) begin
              shift_d = load_byte;
            end
            sda_d = shift_d[7];
          end
          KindRelease:                                 en_d = 1'b0;
          KindDrive:                                   en_d = 1'b1;
          default: ;
        endcase
      end else begin
        load_byte = 8'd0;
      end

      res_d.busy_res = 1'b1;
      phase_inc      = phase_d + 8'd1;
      phase_d        = phase_inc;

      if (phase_inc >= tpp) begin
        phase_d = 8'd0;
        case (kind)
          KindWrLow: begin
            if (bit_d != 3'd7) begin
              bit_d   = bit_d + 3'd1;
              shift_d = {shift_d[6:0], 1'b0};
              nxt     = s - 6'd2;
            end else begin
              bit_d = 3'd0;
            end
          end
          KindAckHigh: begin
            if (in_req_i.sda_in) begin
              nxt = StepFail;
            end
          end
          KindRdHigh: shift_d = {shift_d[6:0], in_req_i.sda_in};
          KindRdLow: begin
            if (bit_d != 3'd7) begin
              bit_d = bit_d + 3'd1;
              nxt   = s - 6'd1;
            end else begin
              bit_d      = 3'd0;
              captured_d = shift_d;
            end
          end
          default: ;
        endcase

        // After the register index, a write goes on to the data byte and a
        // read to the stop that precedes the repeated start.
        if (s == StepRegLast) begin
          nxt = is_read_d ? StepRdStop : StepWrData;
        end

        if (s == StepWrDone || s == StepRdDone || s == StepFailDone) begin
          res_d.done_res = 1'b1;
          res_d.busy_res = 1'b0;
          res_d.failed   = (s == StepFailDone);
          if (s == StepRdDone) begin
            res_d.read_data = captured_d;
          end
          bit_d = 3'd0;
          nxt   = StepIdle;
        end
        step_d = nxt;
      end
    end else begin
      load_byte = 8'd0;
      phase_inc = 8'd0;
    end

    res_d.scl        = scl_d;
    res_d.sda_out    = sda_d;
    res_d.sda_enable = en_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DevAddrReset;
      ticks_q    <= TicksReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_e'(cfg_index_i))
        CfgDevAddr: dev_addr_q <= cfg_data_i;
        CfgTicks:   ticks_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StepIdle;
      bit_q       <= 3'd0;
      shift_q     <= 8'd0;
      held_reg_q  <= 8'd0;
      held_data_q <= 8'd0;
      is_read_q   <= 1'b0;
      phase_q     <= 8'd0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      en_q        <= 1'b1;
      captured_q  <= 8'd0;
    end else if (accept) begin
      step_q      <= step_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      held_reg_q  <= held_reg_d;
      held_data_q <= held_data_d;
      is_read_q   <= is_read_d;
      phase_q     <= phase_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      en_q        <= en_d;
      captured_q  <= captured_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_res_q <= res_d;
    end
  end

  // The sequencer never rests on a step beyond the failure stop.
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= StepFailDone)
    else $error("sequence step out of range");

  // A finishing tick never reports busy.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_res_o.done_res && out_res_o.busy_res))
    else $error("done and busy together");

  // Failure and read data are only reported on a finishing tick.
  a_status_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_res_o.failed || out_res_o.read_data != 8'd0)
    |-> out_res_o.done_res)
    else $error("status without done");

  // A finished transaction always leaves the sequencer idle.
  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res_d.done_res |=> step_q == StepIdle)
    else $error("sequencer not idle after done");

endmodule

`default_nettype wire
